/* hdl/nmea_rmc_gga_field_extractor_unit_macros.svh */
// Assertion helpers for the parser of the sentence field extractor.
// Every macro samples on the rising edge of clock and is off during reset.
`ifndef NMEA_RMC_GGA_FIELD_EXTRACTOR_UNIT_MACROS_SVH
`define NMEA_RMC_GGA_FIELD_EXTRACTOR_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define NRGE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nrge assertion failed");

// The consequent holds in the cycle after the antecedent.
`define NRGE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nrge assertion failed");

`endif

/* hdl/nrge_pkg.sv */
package nrge_pkg;

   typedef logic [0:5][7:0] hdr_type;

   localparam hdr_type RMC_HDR = {8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};
   localparam hdr_type GGA_HDR = {8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};

   localparam logic [7:0] DOLLAR_CHAR = 8'h24;
   localparam logic [7:0] COMMA_CHAR = 8'h2C;
   localparam logic [7:0] ZERO_CHAR = 8'h30;
   localparam logic [15:0] SAT_RESET = 16'h3030;

   localparam logic [2:0] HDR_DONE = 3'd6;
   localparam logic [3:0] COMMA_MAX = 4'd15;
   localparam logic [3:0] DATE_COMMA = 4'd9;
   localparam logic [3:0] LAT_COMMA = 4'd2;
   localparam logic [3:0] LON_COMMA = 4'd4;
   localparam logic [3:0] FIX_COMMA = 4'd6;
   localparam logic [3:0] SAT_COMMA = 4'd7;
   localparam int COORD_SLOTS = 11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic last_byte;
      logic time_request;
   } item_type;

   typedef struct packed {
      logic status;
      logic rmc_found;
      logic time_date_valid;
      logic [47:0] date_chars;
      logic [47:0] time_chars;
      logic fix_state;
      logic [15:0] sat_chars;
      logic [63:0] lat_high;
      logic [23:0] lat_low;
      logic [63:0] lon_high;
      logic [23:0] lon_low;
      logic gga_found;
   } rsp_type;

   function automatic logic [2:0] match_next(input logic [2:0] pos, input logic [7:0] b,
                                             input hdr_type hdr);
      logic [2:0] result;
      if (pos >= HDR_DONE) begin
         result = HDR_DONE;
      end else if (b == hdr[pos]) begin
         result = pos + 3'd1;
      end else if (b == DOLLAR_CHAR) begin
         result = 3'd1;
      end else begin
         result = 3'd0;
      end
      return result;
   endfunction

endpackage

/* hdl/nrge_in_queue.sv */
module nrge_in_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  nrge_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output nrge_pkg::item_type head_item,
   output logic empty
);

   nrge_pkg::item_type slot_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 3'd4);
   assign empty = (count_ff == 3'd0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in = count_ff + {2'd0, do_push} - {2'd0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/nrge_rsp_queue.sv */
module nrge_rsp_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  nrge_pkg::rsp_type push_rsp,
   output logic full,
   input  logic pop,
   output nrge_pkg::rsp_type head_rsp,
   output logic empty
);

   nrge_pkg::rsp_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head_rsp = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ do_push;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rsp;
      end
   end

endmodule

/* hdl/nrge_parser.sv */
`include "nmea_rmc_gga_field_extractor_unit_macros.svh"

module nrge_parser #(
   parameter int COORD_CHARS = 11
) (
   input  logic clock,
   input  logic reset,
   input  nrge_pkg::item_type item,
   input  logic item_empty,
   output logic item_pop,
   input  logic rsp_full,
   output logic rsp_push,
   output nrge_pkg::rsp_type rsp
);

   localparam int CAP_LIMIT =
      (COORD_CHARS < nrge_pkg::COORD_SLOTS) ? COORD_CHARS : nrge_pkg::COORD_SLOTS;

   logic take, req_eff, last_take, fixed, valid;
   logic [7:0] d;

   logic in_buffer_ff, in_buffer_in;
   logic req_ff, req_in;
   logic [2:0] rmc_pos_ff, rmc_pos_in;
   logic [2:0] gga_pos_ff, gga_pos_in;
   logic [3:0] rmc_commas_ff, rmc_commas_in;
   logic [3:0] gga_commas_ff, gga_commas_in;
   logic [2:0] time_idx_ff, time_idx_in;
   logic [2:0] date_idx_ff, date_idx_in;
   logic [1:0] date_flags_ff, date_flags_in;
   logic [0:5][7:0] time_ff, time_in;
   logic [0:5][7:0] date_ff, date_in;
   logic [3:0] lat_idx_ff, lat_idx_in;
   logic [3:0] lon_idx_ff, lon_idx_in;
   logic [0:10][7:0] lat_cap_ff, lat_cap_in;
   logic [0:10][7:0] lon_cap_ff, lon_cap_in;
   logic fix_seen_ff, fix_seen_in;
   logic gga_fixed_ff, gga_fixed_in;
   logic [1:0] sat_idx_ff, sat_idx_in;
   logic [0:1][7:0] sat_cap_ff, sat_cap_in;

   logic sticky_ff, sticky_in;
   logic [15:0] sat_store_ff, sat_store_in;
   logic [87:0] lat_store_ff, lat_store_in;
   logic [87:0] lon_store_ff, lon_store_in;

   assign d = item.data_byte;
   assign take = !item_empty && !(item.last_byte && rsp_full);
   assign item_pop = take;
   assign last_take = take && item.last_byte;
   assign req_eff = in_buffer_ff ? req_ff : item.time_request;

   always_comb begin
      in_buffer_in = in_buffer_ff;
      req_in = req_ff;
      rmc_pos_in = rmc_pos_ff;
      gga_pos_in = gga_pos_ff;
      rmc_commas_in = rmc_commas_ff;
      gga_commas_in = gga_commas_ff;
      time_idx_in = time_idx_ff;
      date_idx_in = date_idx_ff;
      date_flags_in = date_flags_ff;
      time_in = time_ff;
      date_in = date_ff;
      lat_idx_in = lat_idx_ff;
      lon_idx_in = lon_idx_ff;
      lat_cap_in = lat_cap_ff;
      lon_cap_in = lon_cap_ff;
      fix_seen_in = fix_seen_ff;
      gga_fixed_in = gga_fixed_ff;
      sat_idx_in = sat_idx_ff;
      sat_cap_in = sat_cap_ff;
      if (take) begin
         in_buffer_in = 1'b1;
         req_in = req_eff;
         if (req_eff) begin
            if (rmc_pos_ff == nrge_pkg::HDR_DONE) begin
               if (time_idx_ff < 3'd7) begin
                  if (time_idx_ff != 3'd0) begin
                     time_in[time_idx_ff - 3'd1] = d;
                  end
                  time_idx_in = time_idx_ff + 3'd1;
               end
               if (rmc_commas_ff >= nrge_pkg::DATE_COMMA && date_idx_ff < 3'd6) begin
                  date_in[date_idx_ff] = d;
                  if (date_idx_ff == 3'd0 && d != nrge_pkg::COMMA_CHAR) begin
                     date_flags_in[0] = 1'b1;
                  end
                  if (date_idx_ff == 3'd1 && d != nrge_pkg::COMMA_CHAR) begin
                     date_flags_in[1] = 1'b1;
                  end
                  date_idx_in = date_idx_ff + 3'd1;
               end
               if (d == nrge_pkg::COMMA_CHAR && rmc_commas_ff < nrge_pkg::COMMA_MAX) begin
                  rmc_commas_in = rmc_commas_ff + 4'd1;
               end
            end else begin
               rmc_pos_in = nrge_pkg::match_next(rmc_pos_ff, d, nrge_pkg::RMC_HDR);
            end
         end
         if (gga_pos_ff == nrge_pkg::HDR_DONE) begin
            if (gga_commas_ff >= nrge_pkg::LAT_COMMA && lat_idx_ff < 4'(CAP_LIMIT)) begin
               lat_cap_in[lat_idx_ff] = d;
               lat_idx_in = lat_idx_ff + 4'd1;
            end
            if (gga_commas_ff >= nrge_pkg::LON_COMMA && lon_idx_ff < 4'(CAP_LIMIT)) begin
               lon_cap_in[lon_idx_ff] = d;
               lon_idx_in = lon_idx_ff + 4'd1;
            end
            if (gga_commas_ff >= nrge_pkg::FIX_COMMA && !fix_seen_ff) begin
               fix_seen_in = 1'b1;
               gga_fixed_in = (d != nrge_pkg::ZERO_CHAR);
            end
            if (gga_commas_ff >= nrge_pkg::SAT_COMMA && sat_idx_ff < 2'd2) begin
               sat_cap_in[sat_idx_ff[0]] = d;
               sat_idx_in = sat_idx_ff + 2'd1;
            end
            if (d == nrge_pkg::COMMA_CHAR && gga_commas_ff < nrge_pkg::COMMA_MAX) begin
               gga_commas_in = gga_commas_ff + 4'd1;
            end
         end else begin
            gga_pos_in = nrge_pkg::match_next(gga_pos_ff, d, nrge_pkg::GGA_HDR);
         end
      end
   end

   always_comb begin
      fixed = (gga_pos_in == nrge_pkg::HDR_DONE) && gga_fixed_in;
      valid = (rmc_pos_in == nrge_pkg::HDR_DONE) && (date_flags_in == 2'b11);
      sticky_in = sticky_ff;
      sat_store_in = sat_store_ff;
      lat_store_in = lat_store_ff;
      lon_store_in = lon_store_ff;
      if (last_take && fixed) begin
         sticky_in = 1'b1;
         sat_store_in = sat_cap_in;
         lat_store_in = lat_cap_in;
         lon_store_in = lon_cap_in;
      end
      rsp.status = !fixed;
      rsp.rmc_found = (rmc_pos_in == nrge_pkg::HDR_DONE);
      rsp.time_date_valid = valid;
      rsp.date_chars = valid ? date_in : 48'd0;
      rsp.time_chars = valid ? time_in : 48'd0;
      rsp.fix_state = sticky_in;
      rsp.sat_chars = sat_store_in;
      rsp.lat_high = lat_store_in[87:24];
      rsp.lat_low = lat_store_in[23:0];
      rsp.lon_high = lon_store_in[87:24];
      rsp.lon_low = lon_store_in[23:0];
      rsp.gga_found = (gga_pos_in == nrge_pkg::HDR_DONE);
      rsp_push = last_take;
   end

   always_ff @(posedge clock) begin
      if (reset || last_take) begin
         in_buffer_ff <= 1'b0;
         req_ff <= 1'b0;
         rmc_pos_ff <= '0;
         gga_pos_ff <= '0;
         rmc_commas_ff <= '0;
         gga_commas_ff <= '0;
         time_idx_ff <= '0;
         date_idx_ff <= '0;
         date_flags_ff <= '0;
         time_ff <= '0;
         date_ff <= '0;
         lat_idx_ff <= '0;
         lon_idx_ff <= '0;
         lat_cap_ff <= '0;
         lon_cap_ff <= '0;
         fix_seen_ff <= 1'b0;
         gga_fixed_ff <= 1'b0;
         sat_idx_ff <= '0;
         sat_cap_ff <= '0;
      end else begin
         in_buffer_ff <= in_buffer_in;
         req_ff <= req_in;
         rmc_pos_ff <= rmc_pos_in;
         gga_pos_ff <= gga_pos_in;
         rmc_commas_ff <= rmc_commas_in;
         gga_commas_ff <= gga_commas_in;
         time_idx_ff <= time_idx_in;
         date_idx_ff <= date_idx_in;
         date_flags_ff <= date_flags_in;
         time_ff <= time_in;
         date_ff <= date_in;
         lat_idx_ff <= lat_idx_in;
         lon_idx_ff <= lon_idx_in;
         lat_cap_ff <= lat_cap_in;
         lon_cap_ff <= lon_cap_in;
         fix_seen_ff <= fix_seen_in;
         gga_fixed_ff <= gga_fixed_in;
         sat_idx_ff <= sat_idx_in;
         sat_cap_ff <= sat_cap_in;
      end
      if (reset) begin
         sticky_ff <= 1'b0;
         sat_store_ff <= nrge_pkg::SAT_RESET;
         lat_store_ff <= '0;
         lon_store_ff <= '0;
      end else begin
         sticky_ff <= sticky_in;
         sat_store_ff <= sat_store_in;
         lat_store_ff <= lat_store_in;
         lon_store_ff <= lon_store_in;
      end
   end

   `NRGE_ASSERT_NEXT(a_buffer_closes, last_take, !in_buffer_ff)
   `NRGE_ASSERT_NEXT(a_sticky_holds, sticky_ff, sticky_ff)
   `NRGE_ASSERT_SAME(a_rmc_needs_request, rmc_pos_ff != 3'd0, req_ff)
   `NRGE_ASSERT_SAME(a_gga_commas_after_hdr, gga_commas_ff != 4'd0,
                     gga_pos_ff == nrge_pkg::HDR_DONE)

endmodule

/* hdl/nmea_rmc_gga_field_extractor_unit.sv */
// Receiver text goes in one byte per beat, with the final byte of a buffer marked; each
// buffer yields one result beat carrying RMC time and date and the GGA fix, satellite
// count and raw coordinate characters. The parser consumes one byte per cycle while the
// result queue can take a final byte, so the sustained rate is one byte beat per cycle;
// a four-entry byte queue feeds the parser and a two-entry result queue holds finished
// results, and a buffer's result enters the result queue when the parser takes its final
// byte. The parser stops only when a final byte meets a full result queue.
module nmea_rmc_gga_field_extractor_unit #(
   parameter int COORD_CHARS = 11
) (
   input  logic clock,
   input  logic reset,
   input  logic [7:0] req_data_byte,
   input  logic req_last_byte,
   input  logic req_time_request,
   input  logic push,
   output logic full,
   output logic rsp_status,
   output logic rsp_rmc_found,
   output logic rsp_time_date_valid,
   output logic [47:0] rsp_date_chars,
   output logic [47:0] rsp_time_chars,
   output logic rsp_fix_state,
   output logic [15:0] rsp_sat_chars,
   output logic [63:0] rsp_lat_high,
   output logic [23:0] rsp_lat_low,
   output logic [63:0] rsp_lon_high,
   output logic [23:0] rsp_lon_low,
   output logic rsp_gga_found,
   output logic empty,
   input  logic pop
);

   nrge_pkg::item_type push_item, head_item;
   nrge_pkg::rsp_type parsed_rsp, head_rsp;
   logic item_empty, item_pop, rsp_full, rsp_push;

   assign push_item.data_byte = req_data_byte;
   assign push_item.last_byte = req_last_byte;
   assign push_item.time_request = req_time_request;

   nrge_in_queue u_in_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .full(full),
      .pop(item_pop),
      .head_item(head_item),
      .empty(item_empty)
   );

   nrge_parser #(
      .COORD_CHARS(COORD_CHARS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .item(head_item),
      .item_empty(item_empty),
      .item_pop(item_pop),
      .rsp_full(rsp_full),
      .rsp_push(rsp_push),
      .rsp(parsed_rsp)
   );

   nrge_rsp_queue u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .push_rsp(parsed_rsp),
      .full(rsp_full),
      .pop(pop),
      .head_rsp(head_rsp),
      .empty(empty)
   );

   assign rsp_status = head_rsp.status;
   assign rsp_rmc_found = head_rsp.rmc_found;
   assign rsp_time_date_valid = head_rsp.time_date_valid;
   assign rsp_date_chars = head_rsp.date_chars;
   assign rsp_time_chars = head_rsp.time_chars;
   assign rsp_fix_state = head_rsp.fix_state;
   assign rsp_sat_chars = head_rsp.sat_chars;
   assign rsp_lat_high = head_rsp.lat_high;
   assign rsp_lat_low = head_rsp.lat_low;
   assign rsp_lon_high = head_rsp.lon_high;
   assign rsp_lon_low = head_rsp.lon_low;
   assign rsp_gga_found = head_rsp.gga_found;

endmodule
